FILE: rtl/pie_pkg.sv
// Shared types and constants for the power-iteration eigenvector block.
// Used by pie_div and power_iteration_eigenvector; depends on nothing.
`default_nettype none

package pie_pkg;

    // Width of one row sum y_i of A*x (Q.24, sum of up to 64 terms).
    localparam int Y_W = 40;
    // Packed width of a result request, padded to whole bytes.
    localparam int OUT_DATA_W = 88;

    // Configuration register indexes.
    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_CAP   = 2'd2;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: rtl/pie_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module pie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/pie_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on pie_pkg for the status struct.
`default_nettype none

module pie_div
    import pie_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] numer,
    input  wire logic [31:0] denom,
    output div_status_t      status,
    output logic      [63:0] quot
);

    logic [63:0] num_reg, num_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [32:0] rem_sh;
    logic        qbit;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[63]};
        qbit      = (rem_sh >= {1'b0, den_reg});
        rem_next  = qbit ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
        num_next  = {num_reg[62:0], qbit};
        cnt_next  = cnt_reg - 7'd1;
        done_next = (cnt_reg == 7'd1);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 7'd64;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != 7'd0)
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath; the dividend register fills with quotient bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (cnt_reg != 7'd0)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = (cnt_reg != 7'd0);
    assign status.done = done_reg;
    assign quot        = num_reg;

endmodule

`default_nettype wire

FILE: rtl/power_iteration_eigenvector.sv
// Power-iteration eigenvector engine. Matrix entries (signed Q8.24, row-major)
// are taken one per cycle into a matrix RAM; the request flagged tlast starts a
// run, during which no input is taken. A run first seeds x = 1/n with one
// division and a write per component. Each step then runs the matrix-vector
// product (one shared multiplier, one RAM read per entry), the square root,
// the normalizing division per component (skipped when the norm is zero) on
// the single bit-serial divider, and the stop check. The n components then
// leave as result requests, each held until the sink takes it. Depends on
// pie_pkg, pie_ram and pie_div.
`default_nettype none

module power_iteration_eigenvector
    import pie_pkg::*;
#(
    parameter int N_MAX = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_write,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    // Input stream. tdata: matrix_element[31:0]. tlast: final_element.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,
    input  wire logic                  s_tlast,
    // Output stream. tdata: vector_element[31:0], vector_index[37:32],
    // dominant_norm[69:38], iterations_done[85:70], zero pad[87:86].
    // tuser: converged. tlast: last_of_run.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam int IDX_W = (N_MAX > 1) ? $clog2(N_MAX) : 1;
    localparam int MA_W  = $clog2(N_MAX * N_MAX);
    localparam int POS_W = $clog2(N_MAX * N_MAX + 1);

    typedef enum logic [15:0] {
        ST_LOAD     = 16'h0001,
        ST_INIT_DIV = 16'h0002,
        ST_INIT_WR  = 16'h0004,
        ST_MV_RD    = 16'h0008,
        ST_MV_MUL   = 16'h0010,
        ST_MV_ACC   = 16'h0020,
        ST_SQ_MUL   = 16'h0040,
        ST_SQ_ACC   = 16'h0080,
        ST_SQRT     = 16'h0100,
        ST_NM_RD    = 16'h0200,
        ST_NM_START = 16'h0400,
        ST_NM_DIV   = 16'h0800,
        ST_NM_ERR   = 16'h1000,
        ST_NM_ACC   = 16'h2000,
        ST_CHECK    = 16'h4000,
        ST_OUT      = 16'h8000
    } state_t;

    // Configuration registers.
    logic [6:0]  size_reg;
    logic [31:0] limit_reg;
    logic [15:0] cap_reg;

    // Control registers.
    state_t             state_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [6:0]         n_reg;
    logic [IDX_W-1:0]   i_reg, j_reg;
    logic [MA_W-1:0]    base_reg;
    logic [15:0]        step_reg;
    logic               conv_reg;
    logic [4:0]         sq_cnt_reg;
    logic               out_valid_reg;
    logic               out_wait_reg;

    // Datapath registers.
    logic [31:0]        xinit_reg;
    logic signed [Y_W-1:0] acc_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        sq_reg, err_reg;
    logic [63:0]        rt_v_reg, rt_res_reg, rt_bit_reg;
    logic [31:0]        norm_reg;
    logic [31:0]        xold_reg, q_reg;
    logic               yneg_reg;
    logic [31:0]        out_elem_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_last_reg;

    // Combinational helpers.
    logic [6:0]         n_now;
    logic [13:0]        nn_full;
    logic [IDX_W-1:0]   nm1;
    logic               s_acc, m_acc, mat_we;
    logic [31:0]        mat_rdata, x_rdata;
    logic [Y_W-1:0]     y_rdata;
    logic               x_we, y_we;
    logic [IDX_W-1:0]   x_waddr, x_raddr;
    logic [31:0]        x_wdata;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [Y_W-1:0] acc_next;
    logic signed [31:0] ysh;
    logic [31:0]        ymag8;
    logic [64:0]        sq_sum, err_sum;
    logic [63:0]        rt_try;
    logic signed [Y_W-1:0] y_s;
    logic [Y_W-1:0]     ymag;
    logic               div_start;
    logic [63:0]        div_numer, div_quot;
    logic [31:0]        div_denom;
    div_status_t        div_st;
    logic [63:0]        qm;
    logic [31:0]        q_sat;
    logic signed [32:0] dlt;
    logic [32:0]        dmag;
    logic [15:0]        step_next;

    // Order in force, clamped to the built range.
    always_comb
    begin
        if (size_reg < 7'd2)
            n_now = 7'd2;
        else if (size_reg > 7'(N_MAX))
            n_now = 7'(N_MAX);
        else
            n_now = size_reg;
        nn_full = 14'(n_now) * 14'(n_now);
    end

    assign nm1    = IDX_W'(n_reg - 7'd1);
    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc  = s_tvalid && s_tready;
    assign m_acc  = out_valid_reg && m_tready;
    assign mat_we = s_acc && (pos_reg < nn_full[POS_W-1:0]);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= 7'd64;
            limit_reg <= 32'd1;
            cap_reg   <= 16'd1000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SIZE:  size_reg  <= cfg_data[6:0];
                REG_LIMIT: limit_reg <= cfg_data;
                REG_CAP:   cap_reg   <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // Memories: matrix, current vector x, row sums y.
    pie_ram #(.WIDTH(32), .DEPTH(N_MAX * N_MAX)) u_mat (
        .clk   (clk),
        .we    (mat_we),
        .waddr (pos_reg[MA_W-1:0]),
        .wdata (s_tdata),
        .raddr (MA_W'(base_reg + MA_W'(j_reg))),
        .rdata (mat_rdata)
    );

    pie_ram #(.WIDTH(32), .DEPTH(N_MAX)) u_x (
        .clk   (clk),
        .we    (x_we),
        .waddr (x_waddr),
        .wdata (x_wdata),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    pie_ram #(.WIDTH(Y_W), .DEPTH(N_MAX)) u_y (
        .clk   (clk),
        .we    (y_we),
        .waddr (i_reg),
        .wdata (acc_next),
        .raddr (i_reg),
        .rdata (y_rdata)
    );

    // Vector memory port selection.
    always_comb
    begin
        x_we    = (state_reg == ST_INIT_WR) || (state_reg == ST_NM_ERR);
        x_waddr = i_reg;
        x_wdata = (state_reg == ST_INIT_WR) ? xinit_reg : q_reg;
        x_raddr = (state_reg == ST_MV_RD) ? j_reg : i_reg;
        y_we    = (state_reg == ST_MV_ACC) && (j_reg == nm1);
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        ysh   = acc_reg[Y_W-1:8];
        ymag8 = ysh[31] ? 32'(-ysh) : 32'(ysh);
        dlt   = $signed({xold_reg[31], xold_reg}) - $signed({q_reg[31], q_reg});
        dmag  = dlt[32] ? 33'(-dlt) : 33'(dlt);
        case (state_reg)
            ST_MV_MUL:
            begin
                mul_a = $signed({mat_rdata[31], mat_rdata});
                mul_b = $signed({x_rdata[31], x_rdata});
            end
            ST_SQ_MUL:
            begin
                mul_a = $signed({1'b0, ymag8});
                mul_b = $signed({1'b0, ymag8});
            end
            default:
            begin
                mul_a = $signed({1'b0, dmag[31:0]});
                mul_b = $signed({1'b0, dmag[31:0]});
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Accumulators and square-root step.
    always_comb
    begin
        acc_next = acc_reg + Y_W'($signed(prod_reg) >>> 30);
        sq_sum   = {1'b0, sq_reg} + {1'b0, prod_reg};
        err_sum  = {1'b0, err_reg} + {1'b0, prod_reg};
        rt_try   = rt_res_reg + rt_bit_reg;
        step_next = step_reg + 16'd1;
    end

    // Divider operands and saturation of the rounded quotient.
    always_comb
    begin
        y_s  = $signed(y_rdata);
        ymag = y_s[Y_W-1] ? Y_W'(-y_s) : Y_W'(y_s);
        div_start = 1'b0;
        div_numer = {33'd0, 31'(32'h4000_0000 + 32'(n_now[6:1]))};
        div_denom = {25'd0, n_now};
        if (state_reg == ST_LOAD)
        begin
            div_start = s_acc && s_tlast;
        end
        else if (state_reg == ST_NM_START)
        begin
            div_start = (norm_reg != 32'd0);
            div_numer = ({(64 - Y_W)'(0), ymag} << 22) + 64'(norm_reg[31:1]);
            div_denom = norm_reg;
        end
        qm = div_quot;
        if (yneg_reg)
            q_sat = (qm > 64'h8000_0000) ? 32'h8000_0000 : 32'(-qm[31:0]);
        else
            q_sat = (qm > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qm[31:0];
    end

    pie_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .numer  (div_numer),
        .denom  (div_denom),
        .status (div_st),
        .quot   (div_quot)
    );

    // Sequencer and control counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            pos_reg       <= '0;
            n_reg         <= 7'd2;
            i_reg         <= '0;
            j_reg         <= '0;
            base_reg      <= '0;
            step_reg      <= '0;
            conv_reg      <= 1'b0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_wait_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (mat_we)
                        pos_reg <= pos_reg + POS_W'(1);
                    if (s_acc && s_tlast)
                    begin
                        pos_reg   <= '0;
                        n_reg     <= n_now;
                        step_reg  <= '0;
                        state_reg <= ST_INIT_DIV;
                    end
                end
                ST_INIT_DIV:
                begin
                    if (div_st.done)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_INIT_WR;
                    end
                end
                ST_INIT_WR:
                begin
                    i_reg <= i_reg + IDX_W'(1);
                    if (i_reg == nm1)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        base_reg  <= '0;
                        state_reg <= ST_MV_RD;
                    end
                end
                ST_MV_RD:  state_reg <= ST_MV_MUL;
                ST_MV_MUL: state_reg <= ST_MV_ACC;
                ST_MV_ACC:
                begin
                    j_reg <= j_reg + IDX_W'(1);
                    state_reg <= (j_reg == nm1) ? ST_SQ_MUL : ST_MV_RD;
                end
                ST_SQ_MUL: state_reg <= ST_SQ_ACC;
                ST_SQ_ACC:
                begin
                    j_reg <= '0;
                    if (i_reg == nm1)
                    begin
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_SQRT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        base_reg  <= base_reg + MA_W'(n_reg);
                        state_reg <= ST_MV_RD;
                    end
                end
                ST_SQRT:
                begin
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == 5'd31)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_NM_RD;
                    end
                end
                ST_NM_RD: state_reg <= ST_NM_START;
                ST_NM_START:
                    state_reg <= (norm_reg != 32'd0) ? ST_NM_DIV : ST_NM_ERR;
                ST_NM_DIV:
                begin
                    if (div_st.done)
                        state_reg <= ST_NM_ERR;
                end
                ST_NM_ERR: state_reg <= ST_NM_ACC;
                ST_NM_ACC:
                begin
                    i_reg <= i_reg + IDX_W'(1);
                    state_reg <= (i_reg == nm1) ? ST_CHECK : ST_NM_RD;
                end
                ST_CHECK:
                begin
                    step_reg <= step_next;
                    i_reg    <= '0;
                    j_reg    <= '0;
                    base_reg <= '0;
                    if (err_reg <= 64'(limit_reg))
                    begin
                        conv_reg     <= 1'b1;
                        out_wait_reg <= 1'b0;
                        state_reg    <= ST_OUT;
                    end
                    else if (step_next >= cap_reg)
                    begin
                        conv_reg     <= 1'b0;
                        out_wait_reg <= 1'b0;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_MV_RD;
                    end
                end
                ST_OUT:
                begin
                    // Read x[i], present it, wait for the request to be taken.
                    if (!out_valid_reg && !out_wait_reg)
                    begin
                        out_wait_reg <= 1'b1;
                    end
                    else if (out_wait_reg)
                    begin
                        out_wait_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                    end
                    else if (m_acc)
                    begin
                        out_valid_reg <= 1'b0;
                        i_reg <= i_reg + IDX_W'(1);
                        if (out_last_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_p);
        case (state_reg)
            ST_INIT_DIV:
            begin
                if (div_st.done)
                    xinit_reg <= div_quot[31:0];
            end
            ST_INIT_WR:
            begin
                acc_reg <= '0;
                sq_reg  <= '0;
            end
            ST_MV_ACC:
            begin
                acc_reg <= acc_next;
            end
            ST_SQ_ACC:
            begin
                acc_reg <= '0;
                sq_reg  <= sq_sum[64] ? '1 : sq_sum[63:0];
                rt_v_reg   <= sq_sum[64] ? '1 : sq_sum[63:0];
                rt_res_reg <= '0;
                rt_bit_reg <= 64'h4000_0000_0000_0000;
            end
            ST_SQRT:
            begin
                if (rt_v_reg >= rt_try)
                begin
                    rt_v_reg   <= rt_v_reg - rt_try;
                    rt_res_reg <= (rt_res_reg >> 1) + rt_bit_reg;
                end
                else
                begin
                    rt_res_reg <= rt_res_reg >> 1;
                end
                rt_bit_reg <= rt_bit_reg >> 2;
                if (sq_cnt_reg == 5'd31)
                begin
                    norm_reg <= (rt_v_reg >= rt_try) ?
                                32'((rt_res_reg >> 1) + rt_bit_reg) : 32'(rt_res_reg >> 1);
                    err_reg  <= '0;
                end
            end
            ST_NM_START:
            begin
                xold_reg <= x_rdata;
                yneg_reg <= y_s[Y_W-1];
                q_reg    <= '0;
            end
            ST_NM_DIV:
            begin
                if (div_st.done)
                    q_reg <= q_sat;
            end
            ST_NM_ACC:
            begin
                err_reg <= err_sum[64] ? '1 : err_sum[63:0];
            end
            ST_CHECK:
            begin
                acc_reg <= '0;
                sq_reg  <= '0;
            end
            ST_OUT:
            begin
                if (out_wait_reg)
                begin
                    out_elem_reg <= x_rdata;
                    out_idx_reg  <= i_reg;
                    out_last_reg <= (i_reg == nm1);
                end
            end
            default: ;
        endcase
    end

    // Result request.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, step_reg, norm_reg, 6'(out_idx_reg), out_elem_reg};
    assign m_tuser  = conv_reg;
    assign m_tlast  = out_last_reg;

    // Input is never taken while results are pending.
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input accepted during result delivery");

    // The divider is only started when idle.
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

    // A presented component lies within the matrix order.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> out_idx_reg <= nm1)
        else $error("component index beyond order");

    // Every run reports at least one step.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> step_reg != 16'd0)
        else $error("result with no step performed");

endmodule

`default_nettype wire
